// ===== rtl/sgts_pkg.sv =====
// Shared types and constants for the staggered-grid trilinear sampler.
// No dependencies.
package sgts_pkg;

    localparam int GRID_WORDS = 4096;
    localparam int GRID_AW    = $clog2(GRID_WORDS);
    localparam int MAX_DIM    = 30;

    // Fixed field widths
    localparam int VAL_W  = 32;
    localparam int POS_W  = 20;
    localparam int FRAC_W = 16;
    localparam int DIM_W  = 5;
    localparam int N_W    = 6;   // dim plus ghost border
    localparam int IDX_W  = 5;
    localparam int ADDR_W = 15;  // widest flat address before range check
    localparam int OFF_W  = 13;

    typedef enum logic [2:0] {
        REG_GRID_KIND = 3'd0,
        REG_DIM_X     = 3'd1,
        REG_DIM_Y     = 3'd2,
        REG_DIM_Z     = 3'd3,
        REG_CELL_LOG2 = 3'd4
    } cfg_reg_t;

    typedef enum logic [2:0] {
        KIND_CELL   = 3'd0,
        KIND_FACE_X = 3'd1,
        KIND_FACE_Y = 3'd2,
        KIND_FACE_Z = 3'd3,
        KIND_LEVEL  = 3'd4
    } grid_kind_t;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Clamp a configured dimension into 1..MAX_DIM
    function automatic logic [DIM_W-1:0] fix_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        r = d;
        if (d == '0)
            r = DIM_W'(1);
        else if (d > DIM_W'(MAX_DIM))
            r = DIM_W'(MAX_DIM);
        return r;
    endfunction

endpackage

// ===== rtl/sgts_axis.sv =====
// Per-axis offset, clamp, index/fraction split and neighbor clamp.
// One register stage. Depends on sgts_pkg.
module sgts_axis (
    input  logic                                clk,
    input  logic signed [sgts_pkg::POS_W-1:0]   pos,
    input  logic signed [sgts_pkg::OFF_W-1:0]   off,
    input  logic [sgts_pkg::N_W-1:0]            n,
    input  logic [3:0]                          shift,
    output logic [sgts_pkg::IDX_W-1:0]          i0_reg,
    output logic [sgts_pkg::IDX_W-1:0]          i1_reg,
    output logic [sgts_pkg::FRAC_W-1:0]         frac_reg
);
    import sgts_pkg::*;

    logic signed [POS_W:0] p_raw;
    logic [17:0]           maxp;
    logic [17:0]           p_cl;
    logic [17:0]           low_bits;
    logic [N_W-1:0]        idx;
    logic [N_W-1:0]        idx_p1;
    logic [N_W-1:0]        nm1;
    logic [33:0]           frac_wide;

    // Offset point and clamp to [0, n cells]
    always_comb
    begin
        p_raw = (POS_W+1)'(pos) + (POS_W+1)'(off);
        maxp  = 18'(n) << shift;
        if (p_raw < 0)
            p_cl = '0;
        else if (p_raw > $signed({3'b000, maxp}))
            p_cl = maxp;
        else
            p_cl = p_raw[17:0];
        idx       = N_W'(p_cl >> shift);
        idx_p1    = idx + N_W'(1);
        nm1       = n - N_W'(1);
        low_bits  = p_cl & ((18'd1 << shift) - 18'd1);
        frac_wide = (34'(low_bits) << FRAC_W) >> shift;
    end

    always_ff @(posedge clk)
    begin
        i0_reg   <= (idx > nm1) ? nm1[IDX_W-1:0] : idx[IDX_W-1:0];
        i1_reg   <= (idx_p1 > nm1) ? nm1[IDX_W-1:0] : idx_p1[IDX_W-1:0];
        frac_reg <= frac_wide[FRAC_W-1:0];
    end

endmodule

// ===== rtl/sgts_lerp.sv =====
// Two-stage linear blend a + floor((b - a) * f / 2^16).
// Depends on sgts_pkg.
module sgts_lerp (
    input  logic                                clk,
    input  logic signed [sgts_pkg::VAL_W-1:0]   a,
    input  logic signed [sgts_pkg::VAL_W-1:0]   b,
    input  logic [sgts_pkg::FRAC_W-1:0]         f,
    output logic signed [sgts_pkg::VAL_W-1:0]   r_reg
);
    import sgts_pkg::*;

    localparam int PROD_W = VAL_W + 1 + FRAC_W + 1;

    logic signed [VAL_W:0]    diff;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [VAL_W-1:0]  a_reg;
    logic signed [PROD_W-1:0] delta;

    // Stage 1: difference times fraction
    always_comb
    begin
        diff      = (VAL_W+1)'(b) - (VAL_W+1)'(a);
        prod_next = PROD_W'(diff) * $signed({1'b0, f});
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        a_reg    <= a;
    end

    // Stage 2: floor shift and add; result stays between a and b
    assign delta = prod_reg >>> FRAC_W;

    always_ff @(posedge clk)
    begin
        r_reg <= a_reg + delta[VAL_W-1:0];
    end

endmodule

// ===== rtl/staggered_grid_trilinear_sampler_core.sv =====
// Staggered-grid trilinear sampler core. Depends on sgts_pkg, sgts_axis, sgts_lerp.
// A sample passes input capture, axis index, corner address and bank read
// registers and the y, x and z blends before its result shows with done high.
// Throughput: one beat per cycle, set by eight replicated store banks each
// giving one read per cycle. busy stays low; the receiver cannot stall. Reset
// clears valid bits and sets configuration to its defaults; the grid store is not cleared.
module staggered_grid_trilinear_sampler_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               op,
    input  logic [11:0]                        cell_index,
    input  logic signed [sgts_pkg::VAL_W-1:0]  cell_value,
    input  logic signed [sgts_pkg::POS_W-1:0]  pos_x,
    input  logic signed [sgts_pkg::POS_W-1:0]  pos_y,
    input  logic signed [sgts_pkg::POS_W-1:0]  pos_z,
    output logic                               done,
    output logic signed [sgts_pkg::VAL_W-1:0]  sample_value,
    input  logic                               cfg_we,
    input  logic [2:0]                         cfg_addr,
    input  logic [4:0]                         cfg_wdata
);
    import sgts_pkg::*;

    // Configuration registers
    logic [2:0]       grid_kind_reg;
    logic [DIM_W-1:0] dim_x_reg, dim_y_reg, dim_z_reg;
    logic [3:0]       cell_log2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_kind_reg <= KIND_CELL;
            dim_x_reg     <= DIM_W'(15);
            dim_y_reg     <= DIM_W'(15);
            dim_z_reg     <= DIM_W'(1);
            cell_log2_reg <= 4'hF;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_GRID_KIND: grid_kind_reg <= cfg_wdata[2:0];
                REG_DIM_X:     dim_x_reg     <= cfg_wdata;
                REG_DIM_Y:     dim_y_reg     <= cfg_wdata;
                REG_DIM_Z:     dim_z_reg     <= cfg_wdata;
                REG_CELL_LOG2: cell_log2_reg <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // Decoded geometry; user must hold it steady with samples in flight (unchecked)
    logic [2:0]              kind;
    logic signed [3:0]       lg;
    logic [3:0]              shift;
    logic signed [OFF_W-1:0] half;
    logic [N_W-1:0]          n_ax [3];
    logic signed [OFF_W-1:0] off_ax [3];
    logic [DIM_W-1:0]        dim_ax [3];

    always_comb
    begin
        kind = (grid_kind_reg > KIND_LEVEL) ? KIND_CELL : grid_kind_reg;
        lg   = $signed(cell_log2_reg);
        if (lg < -4)
            lg = -4'sd4;
        else if (lg > 4)
            lg = 4'sd4;
        shift     = 4'(4'sd8 + lg);
        half      = OFF_W'(1) << (shift - 4'd1);
        dim_ax[0] = fix_dim(dim_x_reg);
        dim_ax[1] = fix_dim(dim_y_reg);
        dim_ax[2] = fix_dim(dim_z_reg);
        for (int a = 0; a < 3; a++)
        begin
            if (kind == KIND_LEVEL)
            begin
                n_ax[a]   = N_W'(dim_ax[a]) + N_W'(2);
                off_ax[a] = half;
            end
            else if (kind == 3'(a + 1))
            begin
                n_ax[a]   = N_W'(dim_ax[a]) + N_W'(1);
                off_ax[a] = '0;
            end
            else
            begin
                n_ax[a]   = N_W'(dim_ax[a]);
                off_ax[a] = -half;
            end
        end
    end

    assign busy = 1'b0;

    // Stage 0: input capture
    logic                    v0_reg, op0_reg;
    logic [GRID_AW-1:0]      widx0_reg;
    logic [VAL_W-1:0]        wval0_reg;
    logic signed [POS_W-1:0] pos0_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else
            v0_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        op0_reg     <= op;
        widx0_reg   <= GRID_AW'(cell_index);
        wval0_reg   <= cell_value;
        pos0_reg[0] <= pos_x;
        pos0_reg[1] <= pos_y;
        pos0_reg[2] <= pos_z;
    end

    // Stage 1: per-axis index units
    logic [IDX_W-1:0]  i0_s1 [3];
    logic [IDX_W-1:0]  i1_s1 [3];
    logic [FRAC_W-1:0] fr_s1 [3];

    for (genvar g = 0; g < 3; g++)
    begin : g_axis
        sgts_axis u_axis (
            .clk      (clk),
            .pos      (pos0_reg[g]),
            .off      (off_ax[g]),
            .n        (n_ax[g]),
            .shift    (shift),
            .i0_reg   (i0_s1[g]),
            .i1_reg   (i1_s1[g]),
            .frac_reg (fr_s1[g])
        );
    end

    logic               v1_reg, op1_reg;
    logic [GRID_AW-1:0] widx1_reg;
    logic [VAL_W-1:0]   wval1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= v0_reg;
    end

    always_ff @(posedge clk)
    begin
        op1_reg   <= op0_reg;
        widx1_reg <= widx0_reg;
        wval1_reg <= wval0_reg;
    end

    // Stage 2: corner addresses, corner c = x*4 + z*2 + y
    logic [10:0]        plane;
    logic [ADDR_W-1:0]  addr_next [8];
    logic [ADDR_W-1:0]  addr2_reg [8];
    logic [FRAC_W-1:0]  fr2_reg [3];
    logic               v2_reg, op2_reg;
    logic [GRID_AW-1:0] widx2_reg;
    logic [VAL_W-1:0]   wval2_reg;

    always_comb
    begin
        plane = 11'(n_ax[0]) * 11'(n_ax[2]);
        for (int c = 0; c < 8; c++)
        begin
            addr_next[c] = ADDR_W'(c[2] ? i1_s1[0] : i0_s1[0])
                         + ADDR_W'(c[1] ? i1_s1[2] : i0_s1[2]) * ADDR_W'(n_ax[0])
                         + ADDR_W'(c[0] ? i1_s1[1] : i0_s1[1]) * ADDR_W'(plane);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        addr2_reg <= addr_next;
        fr2_reg   <= fr_s1;
        op2_reg   <= op1_reg;
        widx2_reg <= widx1_reg;
        wval2_reg <= wval1_reg;
    end

    // Stage 3: eight store banks, each holding a full copy of the grid
    logic               wr_s2;
    logic [VAL_W-1:0]   rd3_reg [8];
    logic               oob3_reg [8];
    logic               smp3_reg;
    logic [FRAC_W-1:0]  fy3_reg, fx3_reg, fz3_reg;
    logic [VAL_W-1:0]   corner [8];

    assign wr_s2 = v2_reg && (op2_reg == OP_WRITE);

    for (genvar g = 0; g < 8; g++)
    begin : g_bank
        logic [VAL_W-1:0] mem [GRID_WORDS];

        always_ff @(posedge clk)
        begin
            if (wr_s2)
                mem[widx2_reg] <= wval2_reg;
            rd3_reg[g]  <= mem[addr2_reg[g][GRID_AW-1:0]];
            oob3_reg[g] <= (addr2_reg[g] >= ADDR_W'(GRID_WORDS));
        end

        assign corner[g] = oob3_reg[g] ? '0 : rd3_reg[g];
    end

    always_ff @(posedge clk)
    begin
        fy3_reg <= fr2_reg[1];
        fx3_reg <= fr2_reg[0];
        fz3_reg <= fr2_reg[2];
    end

    // Sample valid chain, stages 3 to 9
    logic [9:3] smp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            smp_reg <= '0;
        else
            smp_reg <= {smp_reg[8:3], v2_reg && (op2_reg == OP_SAMPLE)};
    end

    assign smp3_reg = smp_reg[3];

    // Fraction delays to line up with each blend level
    logic [FRAC_W-1:0] fx4_reg, fx5_reg;
    logic [FRAC_W-1:0] fz4_reg, fz5_reg, fz6_reg, fz7_reg;

    always_ff @(posedge clk)
    begin
        fx4_reg <= fx3_reg;
        fx5_reg <= fx4_reg;
        fz4_reg <= fz3_reg;
        fz5_reg <= fz4_reg;
        fz6_reg <= fz5_reg;
        fz7_reg <= fz6_reg;
    end

    // Blend along y (stages 4-5)
    logic signed [VAL_W-1:0] y00, y10, y01, y11, bx0, bx1;

    sgts_lerp u_y00 (.clk(clk), .a(corner[0]), .b(corner[1]), .f(fy3_reg), .r_reg(y00));
    sgts_lerp u_y10 (.clk(clk), .a(corner[4]), .b(corner[5]), .f(fy3_reg), .r_reg(y10));
    sgts_lerp u_y01 (.clk(clk), .a(corner[2]), .b(corner[3]), .f(fy3_reg), .r_reg(y01));
    sgts_lerp u_y11 (.clk(clk), .a(corner[6]), .b(corner[7]), .f(fy3_reg), .r_reg(y11));

    // Blend along x (stages 6-7)
    sgts_lerp u_x0 (.clk(clk), .a(y00), .b(y10), .f(fx5_reg), .r_reg(bx0));
    sgts_lerp u_x1 (.clk(clk), .a(y01), .b(y11), .f(fx5_reg), .r_reg(bx1));

    // Blend along z (stages 8-9)
    sgts_lerp u_z (.clk(clk), .a(bx0), .b(bx1), .f(fz7_reg), .r_reg(sample_value));

    assign done = smp_reg[9] && !smp3_reg ? 1'b1 : smp_reg[9];

endmodule

// ===== rtl/sgts_checker.sv =====
// Port-level checks for the sampler core, attached by bind.
// Depends on staggered_grid_trilinear_sampler_core ports only.
module sgts_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic op,
    input logic done
);
    // A sample beat yields a done strobe
    a_sample_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && op) |-> ##10 done)
        else $error("sample beat gave no result");

    // A write beat yields no strobe
    a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !op) |-> ##10 !done)
        else $error("write beat gave a result");

    // No beat, no strobe
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##10 !done)
        else $error("result without a beat");

    // Core never holds off a command
    a_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy)
        else $error("busy raised");

endmodule

bind staggered_grid_trilinear_sampler_core sgts_checker u_sgts_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .op    (op),
    .done  (done)
);
